// ===== rtl/bounded_deque_engine_defines.svh =====
// Assertion macros shared by the deque engine RTL
`ifndef BOUNDED_DEQUE_ENGINE_DEFINES_SVH
`define BOUNDED_DEQUE_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define BDE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque engine check failed");

// Next-cycle implication, sampled on clk, off while in reset
`define BDE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque engine check failed");

`endif

// ===== rtl/bde_pkg.sv =====
`timescale 1ns / 1ps

package bde_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // command codes
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_FIND       = 3'd4;
    localparam logic [2:0] CMD_REVERSE    = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] operand;
    } req_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic               found;
        logic [4:0]         occupancy;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic               is_empty;
    } rsp_beat_t;

endpackage

// ===== rtl/bounded_deque_engine.sv =====
// Deque engine: one command beat in, one result beat out.
// Sequence: every accepted command passes S_EXEC and then S_DONE, which loads the result once the output slot is free;
// a pop that leaves entries also passes S_READ; a find on a non-empty deque walks S_FIND over 1..16 entries.
// Throughput: one command at a time; the next is taken the cycle after the result is loaded.
// Rate is set by the single ring-store read port, shared by end refresh and the find walk.
// Reset (rst_n low, asynchronous): deque empty, orientation normal; store contents undefined.
`timescale 1ns / 1ps

`include "bounded_deque_engine_defines.svh"

module bounded_deque_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  bde_pkg::req_beat_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output bde_pkg::rsp_beat_t rsp
);
    import bde_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_FIND,
        S_DONE
    } state_t;

    typedef logic signed [DATA_W-1:0] data_t;

    // ring store
    data_t mem [DEPTH];
    data_t rd_data_reg;

    state_t              state_reg, state_next;
    logic [2:0]          cmd_reg, cmd_next;
    data_t               op_reg, op_next;
    logic [ADDR_W-1:0]   start_reg, start_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                rev_reg, rev_next;
    data_t               lo_reg, lo_next;
    data_t               hi_reg, hi_next;
    logic                fill_lo_reg, fill_lo_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [1:0]          status_reg, status_next;
    data_t               removed_reg, removed_next;
    logic                found_reg, found_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_beat_t           rsp_reg, rsp_next;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                at_low;
    logic                is_push;
    logic                is_pop;
    logic                hit;
    logic                last_idx;
    logic                slot_free;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // command decode: which ring end is touched
    assign is_push = (cmd_reg == CMD_PUSH_FRONT) || (cmd_reg == CMD_PUSH_BACK);
    assign is_pop  = (cmd_reg == CMD_POP_FRONT) || (cmd_reg == CMD_POP_BACK);
    assign at_low  = ((cmd_reg == CMD_PUSH_FRONT) || (cmd_reg == CMD_POP_FRONT)) != rev_reg;

    // compare unit for the find walk, and the free-slot check for the result
    assign hit       = (rd_data_reg == op_reg);
    assign last_idx  = ({1'b0, idx_reg} + CNT_W'(1)) == cnt_reg;
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        op_next        = op_reg;
        start_next     = start_reg;
        cnt_next       = cnt_reg;
        rev_next       = rev_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        fill_lo_next   = fill_lo_reg;
        idx_next       = idx_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        found_next     = found_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = start_reg;
        rd_en          = 1'b0;
        rd_addr        = start_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next     = req.command;
                    op_next      = DATA_W'(req.operand);
                    status_next  = ST_OK;
                    removed_next = '0;
                    found_next   = 1'b0;
                    state_next   = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                if (is_push)
                begin
                    if (cnt_reg == CNT_W'(DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (at_low)
                        begin
                            wr_addr    = start_reg - ADDR_W'(1);
                            start_next = start_reg - ADDR_W'(1);
                            lo_next    = op_reg;
                            if (cnt_reg == '0)
                            begin
                                hi_next = op_reg;
                            end
                        end
                        else
                        begin
                            wr_addr = start_reg + cnt_reg[ADDR_W-1:0];
                            hi_next = op_reg;
                            if (cnt_reg == '0)
                            begin
                                lo_next = op_reg;
                            end
                        end
                    end
                end
                else if (is_pop)
                begin
                    if (cnt_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        removed_next = at_low ? lo_reg : hi_reg;
                        cnt_next     = cnt_reg - CNT_W'(1);
                        fill_lo_next = at_low;
                        if (cnt_reg == CNT_W'(1))
                        begin
                            start_next = '0;
                        end
                        else
                        begin
                            // fetch the new end entry
                            rd_en      = 1'b1;
                            state_next = S_READ;
                            if (at_low)
                            begin
                                rd_addr    = start_reg + ADDR_W'(1);
                                start_next = start_reg + ADDR_W'(1);
                            end
                            else
                            begin
                                rd_addr = start_reg + ADDR_W'(cnt_reg - CNT_W'(2));
                            end
                        end
                    end
                end
                else if (cmd_reg == CMD_FIND)
                begin
                    if (cnt_reg != '0)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = start_reg;
                        idx_next   = '0;
                        state_next = S_FIND;
                    end
                end
                else if (cmd_reg == CMD_REVERSE)
                begin
                    rev_next = !rev_reg;
                end
            end

            S_READ:
            begin
                if (fill_lo_reg)
                begin
                    lo_next = rd_data_reg;
                end
                else
                begin
                    hi_next = rd_data_reg;
                end
                state_next = S_DONE;
            end

            S_FIND:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (last_idx)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = start_reg + idx_reg + ADDR_W'(1);
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end

            S_DONE:
            begin
                if (slot_free)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.status        = status_reg;
                    rsp_next.removed_value = 32'(removed_reg);
                    rsp_next.found         = found_reg;
                    rsp_next.occupancy     = 5'(cnt_reg);
                    rsp_next.is_empty      = (cnt_reg == '0);
                    if (cnt_reg == '0)
                    begin
                        rsp_next.front_value = '0;
                        rsp_next.back_value  = '0;
                    end
                    else
                    begin
                        rsp_next.front_value = 32'(rev_reg ? hi_reg : lo_reg);
                        rsp_next.back_value  = 32'(rev_reg ? lo_reg : hi_reg);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= '0;
            cnt_reg       <= '0;
            rev_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            cnt_reg       <= cnt_next;
            rev_reg       <= rev_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        op_reg      <= op_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        fill_lo_reg <= fill_lo_next;
        idx_reg     <= idx_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        found_reg   <= found_next;
        rsp_reg     <= rsp_next;
    end

    // ring store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= op_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // checks
    `BDE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    `BDE_ASSERT_NOW(a_empty_start, cnt_reg == '0, start_reg == '0)
    `BDE_ASSERT_NOW(a_find_range, state_reg == S_FIND, {1'b0, idx_reg} < cnt_reg)
    `BDE_ASSERT_NEXT(a_push_grow, (state_reg == S_EXEC) && is_push && (cnt_reg < CNT_W'(DEPTH)), cnt_reg == $past(cnt_reg) + CNT_W'(1))
    `BDE_ASSERT_NOW(a_rsp_empty, rsp_valid_reg, rsp_reg.is_empty == (rsp_reg.occupancy == '0))

endmodule
